FILE: hw/rtl/fep_pkg.sv
// Shared types, constants and field helpers for the force-feedback packet encoder.
package fep_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 5;

    // Register reset values
    localparam logic [CODE_W-1:0] DOWNLOAD_CODE_RST = 4'd1;
    localparam logic [CODE_W-1:0] STOP_CODE_RST     = 4'd3;
    localparam logic [BYTE_W-1:0] CONSTANT_KIND_RST = 8'd0;
    localparam logic [BYTE_W-1:0] SPRING_KIND_RST   = 8'd11;
    localparam logic [BYTE_W-1:0] DAMPER_KIND_RST   = 8'd12;
    localparam logic [BYTE_W-1:0] FRICTION_KIND_RST = 8'd14;

    localparam logic [BYTE_W-1:0]  SLOT_BIT_BASE = 8'h10;
    localparam logic [16:0]        COEFF_KNEE    = 17'd2048;
    localparam logic [10:0]        DEADBAND_FULL = 11'd2047;

    typedef enum logic [OP_W-1:0] {
        OP_CONSTANT = 3'd0,
        OP_SPRING   = 3'd1,
        OP_DAMPER   = 3'd2,
        OP_FRICTION = 3'd3,
        OP_STOP     = 3'd4
    } t_op;

    // Register word index (byte address / 4)
    typedef enum logic [2:0] {
        REG_DOWNLOAD_CODE = 3'd0,
        REG_STOP_CODE     = 3'd1,
        REG_CONSTANT_KIND = 3'd2,
        REG_SPRING_KIND   = 3'd3,
        REG_DAMPER_KIND   = 3'd4,
        REG_FRICTION_KIND = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CODE_W-1:0] download_code;
        logic [CODE_W-1:0] stop_code;
        logic [BYTE_W-1:0] constant_kind;
        logic [BYTE_W-1:0] spring_kind;
        logic [BYTE_W-1:0] damper_kind;
        logic [BYTE_W-1:0] friction_kind;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [SLOT_W-1:0]         slot;
        logic signed [FIELD_W-1:0] force_req;
        logic signed [FIELD_W-1:0] pos_coeff;
        logic signed [FIELD_W-1:0] neg_coeff;
        logic signed [FIELD_W-1:0] pos_sat;
        logic [FIELD_W-1:0]        dead_band;
        logic signed [FIELD_W-1:0] center_offset;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] kind_byte;
        logic [BYTE_W-1:0] param_a;
        logic [BYTE_W-1:0] param_b;
        logic [BYTE_W-1:0] param_c;
        logic [BYTE_W-1:0] param_d;
        logic [BYTE_W-1:0] param_e;
    } t_pkt;

    // |x| of a 16-bit two's complement value, 0..32768
    function automatic logic [16:0] mag16(input logic [FIELD_W-1:0] x);
        logic [16:0] neg;
        neg = 17'h10000 - {1'b0, x};
        return x[15] ? neg : {1'b0, x};
    endfunction

    // Double, saturate to 0xFFFF, keep top 4 bits
    function automatic logic [3:0] scale4(input logic [16:0] m);
        return (m[16] | m[15]) ? 4'hF : m[14:11];
    endfunction

    // Double, saturate to 0xFFFF, keep top 8 bits
    function automatic logic [7:0] scale8(input logic [16:0] m);
        return (m[16] | m[15]) ? 8'hFF : m[14:7];
    endfunction

    // Offset-binary (add 0x8000 mod 2^16) then top 8 / 11 bits
    function automatic logic [7:0] top8(input logic [FIELD_W-1:0] x);
        return {~x[15], x[14:8]};
    endfunction

    function automatic logic [10:0] top11(input logic [FIELD_W-1:0] x);
        return {~x[15], x[14:5]};
    endfunction

endpackage

FILE: hw/rtl/fep_pack.sv
// Combinational packing of one registered request into a seven-byte packet.
module fep_pack (
    input  fep_pkg::t_cfg i_cfg,
    input  fep_pkg::t_req i_req,
    output fep_pkg::t_pkt o_pkt
);
    import fep_pkg::*;

    logic [16:0]       k1_mag, k2_mag, k1_adj, k2_adj;
    logic              s1, s2, k1_low, k2_low;
    logic [10:0]       d1, d2;
    logic [BYTE_W-1:0] sat_byte, force_byte, slot_bit;

    always_comb begin
        s1       = i_req.neg_coeff[15];
        s2       = i_req.pos_coeff[15];
        k1_mag   = mag16(i_req.neg_coeff);
        k2_mag   = mag16(i_req.pos_coeff);
        k1_low   = k1_mag < COEFF_KNEE;
        k2_low   = k2_mag < COEFF_KNEE;
        k1_adj   = k1_low ? k1_mag : k1_mag - COEFF_KNEE;
        k2_adj   = k2_low ? k2_mag : k2_mag - COEFF_KNEE;
        d1       = k1_low ? 11'd0 : top11(i_req.dead_band);
        d2       = k2_low ? DEADBAND_FULL : top11(i_req.center_offset);
        sat_byte = top8(i_req.pos_sat);
        force_byte = top8(i_req.force_req);
        slot_bit = SLOT_BIT_BASE << i_req.slot;

        o_pkt              = '0;
        o_pkt.command_byte = slot_bit | {{(BYTE_W-CODE_W){1'b0}}, i_cfg.download_code};

        unique case (t_op'(i_req.op))
            OP_CONSTANT: begin
                o_pkt.kind_byte = i_cfg.constant_kind;
                case (i_req.slot)
                    2'd0:    o_pkt.param_a = force_byte;
                    2'd1:    o_pkt.param_b = force_byte;
                    2'd2:    o_pkt.param_c = force_byte;
                    default: o_pkt.param_d = force_byte;
                endcase
            end
            OP_SPRING: begin
                o_pkt.kind_byte = i_cfg.spring_kind;
                o_pkt.param_a   = d1[10:3];
                o_pkt.param_b   = d2[10:3];
                o_pkt.param_c   = {scale4(k2_adj), scale4(k1_adj)};
                o_pkt.param_d   = {d2[2:0], s2, d1[2:0], s1};
                o_pkt.param_e   = sat_byte;
            end
            OP_DAMPER: begin
                o_pkt.kind_byte = i_cfg.damper_kind;
                o_pkt.param_a   = {4'd0, scale4(k1_mag)};
                o_pkt.param_b   = {7'd0, s1};
                o_pkt.param_c   = {4'd0, scale4(k2_mag)};
                o_pkt.param_d   = {7'd0, s2};
                o_pkt.param_e   = sat_byte;
            end
            OP_FRICTION: begin
                o_pkt.kind_byte = i_cfg.friction_kind;
                o_pkt.param_a   = scale8(k1_mag);
                o_pkt.param_b   = scale8(k2_mag);
                o_pkt.param_c   = sat_byte;
                o_pkt.param_d   = {3'd0, s2, 3'd0, s1};
            end
            default: begin
                // stop, and op codes with no meaning
                o_pkt.command_byte = slot_bit | {{(BYTE_W-CODE_W){1'b0}}, i_cfg.stop_code};
            end
        endcase
    end

endmodule

FILE: hw/rtl/force_effect_packet_encoder.sv
// Top level: force-feedback packet encoder with request/result ports and APB registers.
// Result path: an accepted request passes the input reg, then the result reg, which drives the strobe o_done.
// Throughput: one request per clock; busy is never raised, since the single packing stage is combinational.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (i_rst_n low, synchronous): pipeline valids cleared, registers to reset values.
// Payload registers are not reset.
module force_effect_packet_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          start,
    output logic                          busy,
    input  logic [fep_pkg::OP_W-1:0]      i_op,
    input  logic [fep_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [15:0]            i_force_req,
    input  logic signed [15:0]            i_pos_coeff,
    input  logic signed [15:0]            i_neg_coeff,
    input  logic signed [15:0]            i_pos_sat,
    input  logic [15:0]                   i_dead_band,
    input  logic signed [15:0]            i_center_offset,
    // result side
    output logic                          o_done,
    output logic [7:0]                    o_command_byte,
    output logic [7:0]                    o_kind_byte,
    output logic [7:0]                    o_param_a,
    output logic [7:0]                    o_param_b,
    output logic [7:0]                    o_param_c,
    output logic [7:0]                    o_param_d,
    output logic [7:0]                    o_param_e,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fep_pkg::APB_AW-1:0]    paddr,
    input  logic [fep_pkg::APB_DW-1:0]    pwdata,
    output logic [fep_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import fep_pkg::*;

    // ---------------------------------------------------------------
    // Register file. Writes land on the access phase; no wait states.
    // ---------------------------------------------------------------
    t_cfg     r_cfg;
    logic     apb_wr;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.download_code <= DOWNLOAD_CODE_RST;
            r_cfg.stop_code     <= STOP_CODE_RST;
            r_cfg.constant_kind <= CONSTANT_KIND_RST;
            r_cfg.spring_kind   <= SPRING_KIND_RST;
            r_cfg.damper_kind   <= DAMPER_KIND_RST;
            r_cfg.friction_kind <= FRICTION_KIND_RST;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_DOWNLOAD_CODE: r_cfg.download_code <= pwdata[CODE_W-1:0];
                REG_STOP_CODE:     r_cfg.stop_code     <= pwdata[CODE_W-1:0];
                REG_CONSTANT_KIND: r_cfg.constant_kind <= pwdata[BYTE_W-1:0];
                REG_SPRING_KIND:   r_cfg.spring_kind   <= pwdata[BYTE_W-1:0];
                REG_DAMPER_KIND:   r_cfg.damper_kind   <= pwdata[BYTE_W-1:0];
                REG_FRICTION_KIND: r_cfg.friction_kind <= pwdata[BYTE_W-1:0];
                default: ;  // unmapped words are ignored
            endcase
        end
    end

    // Read back, zero-extended; unmapped words read as zero
    always_comb begin
        unique case (reg_idx)
            REG_DOWNLOAD_CODE: prdata = {{(APB_DW-CODE_W){1'b0}}, r_cfg.download_code};
            REG_STOP_CODE:     prdata = {{(APB_DW-CODE_W){1'b0}}, r_cfg.stop_code};
            REG_CONSTANT_KIND: prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.constant_kind};
            REG_SPRING_KIND:   prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.spring_kind};
            REG_DAMPER_KIND:   prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.damper_kind};
            REG_FRICTION_KIND: prdata = {{(APB_DW-BYTE_W){1'b0}}, r_cfg.friction_kind};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 1: capture the request. Nothing upstream ever waits on us,
    // so busy stays low and a request can arrive every cycle.
    // ---------------------------------------------------------------
    logic r_req_vld;
    t_req r_req;
    t_pkt pkt;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_req.op            <= i_op;
            r_req.slot          <= i_slot;
            r_req.force_req     <= i_force_req;
            r_req.pos_coeff     <= i_pos_coeff;
            r_req.neg_coeff     <= i_neg_coeff;
            r_req.pos_sat       <= i_pos_sat;
            r_req.dead_band     <= i_dead_band;
            r_req.center_offset <= i_center_offset;
        end
    end

    // Packing: magnitudes, knee subtract, saturating scale and byte muxing
    fep_pack u_pack (
        .i_cfg (r_cfg),
        .i_req (r_req),
        .o_pkt (pkt)
    );

    // ---------------------------------------------------------------
    // Stage 2: result register, strobed for one cycle per request.
    // ---------------------------------------------------------------
    logic r_done;
    t_pkt r_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_pkt <= pkt;
        end
    end

    assign o_done         = r_done;
    assign o_command_byte = r_pkt.command_byte;
    assign o_kind_byte    = r_pkt.kind_byte;
    assign o_param_a      = r_pkt.param_a;
    assign o_param_b      = r_pkt.param_b;
    assign o_param_c      = r_pkt.param_c;
    assign o_param_d      = r_pkt.param_d;
    assign o_param_e      = r_pkt.param_e;

endmodule
